// ===== hdl/console_line_editor_defines.svh =====
// assertion macros shared by the console line editor
`ifndef CONSOLE_LINE_EDITOR_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("console line editor: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define CLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("console line editor: next-cycle check failed");

`endif

// ===== hdl/cle_pkg.sv =====
// shared types and byte codes of the console line editor
package cle_pkg;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_CTRLX = 8'h18;
    localparam logic [7:0] CH_CTRLC = 8'h03;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_ECHO  = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== hdl/cle_if.sv =====
// valid/ready channels carrying received bytes and result words
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input last, output ready);
endinterface

// ===== hdl/cle_cell.sv =====
// one character cell of the line store chain
module cle_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 4
) (
    input  logic               clk,
    input  cle_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   count,
    input  logic [7:0]         load_byte,
    input  logic [7:0]         next_byte,
    output logic [7:0]         char_byte
);

    logic [7:0] data_reg;

    // shift towards the head wins; load only at the tail slot
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= next_byte;
        end
        else if (ctrl.load && (count == CNT_W'(INDEX)))
        begin
            data_reg <= load_byte;
        end
    end

    assign char_byte = data_reg;

endmodule

// ===== hdl/console_line_editor.sv =====
// console line editor: chain of character cells with a result sequencer
// a byte that yields result words moves the sequencer out of idle on accept,
// and the state it enters pushes the first of them into the output register;
// no new byte is taken until the last is pushed, and tx.ready stalls hold it
// reset: rst_n asynchronous active low clears fill count, sequencer and output valid
// the line store cells are not cleared; only written slots are ever read
module console_line_editor #(
    parameter int LINE_CAPACITY = 14
) (
    input  logic      clk,
    input  logic      rst_n,
    cle_in_if.sink    rx,
    cle_out_if.source tx
);

`include "console_line_editor_defines.svh"

    localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(LINE_CAPACITY - 1);

    // one-hot sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ECHO  = 5'b00010,
        ST_LINE  = 5'b00100,
        ST_END   = 5'b01000,
        ST_ABORT = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       ech_left_reg, ech_left_next;
    logic             line_after_reg, line_after_next;
    logic [7:0]       ech0_reg, ech0_next;
    logic [7:0]       ech1_reg, ech1_next;
    logic [7:0]       ech2_reg, ech2_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    // push side of the output register
    logic             push_en;
    logic             push;
    logic [1:0]       push_kind;
    logic [7:0]       push_data;
    logic             push_last;
    logic             accept;

    cle_pkg::cell_ctrl_t cell_ctrl;
    logic [7:0]          cell_q [LINE_CAPACITY];

    // character chain: head cell 0 feeds the output, each cell takes its
    // upper neighbour on a shift, the tail slot given by the count loads
    genvar gi;
    generate
        for (gi = 0; gi < LINE_CAPACITY; gi++)
        begin : g_cell
            logic [7:0] nb;
            if (gi == LINE_CAPACITY - 1)
            begin : g_tail
                assign nb = 8'h00;
            end
            else
            begin : g_mid
                assign nb = cell_q[gi+1];
            end

            cle_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .count     (cnt_reg),
                .load_byte (rx.rx_byte),
                .next_byte (nb),
                .char_byte (cell_q[gi])
            );
        end
    endgenerate

    assign rx.ready = (state_reg == ST_IDLE);
    assign accept   = rx.valid && rx.ready;
    // output register free or being drained this cycle
    assign push_en  = !out_valid_reg || tx.ready;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ech_left_next   = ech_left_reg;
        line_after_next = line_after_reg;
        ech0_next       = ech0_reg;
        ech1_next       = ech1_reg;
        ech2_next       = ech2_reg;
        cell_ctrl       = '0;
        push            = 1'b0;
        push_kind       = cle_pkg::KIND_ECHO;
        push_data       = 8'h00;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (rx.rx_byte)
                        cle_pkg::CH_BS:
                        begin
                            // backspace on an empty line does nothing
                            if (cnt_reg != '0)
                            begin
                                cnt_next        = cnt_reg - CNT_W'(1);
                                ech0_next       = cle_pkg::CH_BS;
                                ech1_next       = cle_pkg::CH_SPACE;
                                ech2_next       = cle_pkg::CH_BS;
                                ech_left_next   = 2'd3;
                                line_after_next = 1'b0;
                                state_next      = ST_ECHO;
                            end
                        end
                        cle_pkg::CH_CR, cle_pkg::CH_LF:
                        begin
                            state_next = (cnt_reg == '0) ? ST_END : ST_LINE;
                        end
                        cle_pkg::CH_CTRLX:
                        begin
                            cnt_next        = '0;
                            ech0_next       = cle_pkg::CH_CR;
                            ech1_next       = cle_pkg::CH_LF;
                            ech_left_next   = 2'd2;
                            line_after_next = 1'b0;
                            state_next      = ST_ECHO;
                        end
                        cle_pkg::CH_CTRLC, cle_pkg::CH_DEL:
                        begin
                            cnt_next   = '0;
                            state_next = ST_ABORT;
                        end
                        default:
                        begin
                            // ordinary byte: store at the tail, echo it,
                            // flush the line if that filled the store
                            cell_ctrl.load  = 1'b1;
                            cnt_next        = cnt_reg + CNT_W'(1);
                            ech0_next       = rx.rx_byte;
                            ech_left_next   = 2'd1;
                            line_after_next = (cnt_reg == LAST_SLOT);
                            state_next      = ST_ECHO;
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                if (push_en)
                begin
                    push          = 1'b1;
                    push_kind     = cle_pkg::KIND_ECHO;
                    push_data     = ech0_reg;
                    push_last     = (ech_left_reg == 2'd1) && !line_after_reg;
                    ech0_next     = ech1_reg;
                    ech1_next     = ech2_reg;
                    ech_left_next = ech_left_reg - 2'd1;
                    if (ech_left_reg == 2'd1)
                    begin
                        state_next = line_after_reg ? ST_LINE : ST_IDLE;
                    end
                end
            end
            ST_LINE:
            begin
                // count doubles as the emit counter; head cell leaves each word
                if (push_en)
                begin
                    push            = 1'b1;
                    push_kind       = cle_pkg::KIND_CHAR;
                    push_data       = cell_q[0];
                    cell_ctrl.shift = 1'b1;
                    cnt_next        = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (push_en)
                begin
                    push       = 1'b1;
                    push_kind  = cle_pkg::KIND_END;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ABORT:
            begin
                if (push_en)
                begin
                    push       = 1'b1;
                    push_kind  = cle_pkg::KIND_ABORT;
                    push_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: load on push, drop valid once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = push_kind;
            out_data_next  = push_data;
            out_last_next  = push_last;
        end
        else if (tx.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            ech_left_reg   <= '0;
            line_after_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            ech_left_reg   <= ech_left_next;
            line_after_reg <= line_after_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ech0_reg     <= ech0_next;
        ech1_reg     <= ech1_next;
        ech2_reg     <= ech2_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign tx.valid     = out_valid_reg;
    assign tx.kind      = out_kind_reg;
    assign tx.data_byte = out_data_reg;
    assign tx.last      = out_last_reg;

    // fill count never passes the store size
    `CLE_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(LINE_CAPACITY))
    // line emission only runs with characters left in the chain
    `CLE_ASSERT_NOW(a_line_cnt, clk, rst_n, state_reg == ST_LINE, cnt_reg != '0)
    // the final word of a byte hands the sequencer back to idle
    `CLE_ASSERT_NEXT(a_last_idle, clk, rst_n, push && push_last, state_reg == ST_IDLE)
    // a pushed word is never lost: output register holds it next cycle
    `CLE_ASSERT_NEXT(a_push_held, clk, rst_n, push, out_valid_reg)

endmodule
